// File: design/hsb_pkg.sv
// Shared types and constants for the HSB to RGB converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hsb_pkg;

  // Output channel width and full-scale value.
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CHAN_SCALE = 255;

  // Hue sector, 60 degrees each. Codes 6 and 7 cannot occur.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// File: design/hsb_to_rgb_converter.sv
// Top level of the HSB to RGB converter: stream ports and the stage chain.
// Depends on hsb_pkg, hsb_front, hsb_pqt and hsb_out.
`timescale 1ns / 1ps
`default_nettype none

// Converts hue, saturation and brightness (unsigned fractions with FRAC_BITS
// fraction bits, 1.0 = 2^FRAC_BITS) to 8-bit red, green and blue. Hue wraps
// modulo 1.0; saturation and brightness above 1.0 clamp to 1.0. Hue*6 picks
// one of six sectors, its fraction f builds p = v(1-s), q = v(1-sf) and
// t = v(1-s(1-f)); every product truncates, and each channel is
// floor(x*255). The block is stateless and fully pipelined: it accepts one
// item per clock while no stage is stalled; each item passes through the input
// stage, two multiplier stages and output register. The depth is set by the
// two chained multiplies for q and t. Each stage holds its item while the
// next one is stalled, so back-pressure on the master side loses nothing;
// s_axis_tready drops only once every stage holds an item.
module hsb_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  // hue_frac, saturation_frac, brightness_frac, each FRAC_BITS+1 bits,
  // from bit 0 up; zero padded to whole bytes
  input  wire  [8*((3*(FRAC_BITS+1)+7)/8)-1:0] s_axis_tdata,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [3*hsb_pkg::CHAN_W-1:0] m_axis_tdata
);
  import hsb_pkg::*;

  localparam int unsigned VAL_W = FRAC_BITS + 1;

  // front -> multiplier stages
  logic                 fr_valid;
  logic                 fr_ready;
  sector_t              fr_sector;
  logic [FRAC_BITS-1:0] fr_f;
  logic [VAL_W-1:0]     fr_s;
  logic [VAL_W-1:0]     fr_v;

  // multiplier stages -> output stage
  logic                 mu_valid;
  logic                 mu_ready;
  sector_t              mu_sector;
  logic [VAL_W-1:0]     mu_v;
  logic [VAL_W-1:0]     mu_p;
  logic [VAL_W-1:0]     mu_q;
  logic [VAL_W-1:0]     mu_t;

  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;

  hsb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .hue_frac        (s_axis_tdata[VAL_W-1:0]),
    .saturation_frac (s_axis_tdata[2*VAL_W-1:VAL_W]),
    .brightness_frac (s_axis_tdata[3*VAL_W-1:2*VAL_W]),
    .out_valid       (fr_valid),
    .out_ready       (fr_ready),
    .sector          (fr_sector),
    .f_frac          (fr_f),
    .s_val           (fr_s),
    .v_val           (fr_v)
  );

  hsb_pqt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pqt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fr_valid),
    .in_ready   (fr_ready),
    .sector_in  (fr_sector),
    .f_frac     (fr_f),
    .s_val      (fr_s),
    .v_in       (fr_v),
    .out_valid  (mu_valid),
    .out_ready  (mu_ready),
    .sector_out (mu_sector),
    .v_out      (mu_v),
    .p_out      (mu_p),
    .q_out      (mu_q),
    .t_out      (mu_t)
  );

  hsb_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mu_valid),
    .in_ready  (mu_ready),
    .sector    (mu_sector),
    .v_val     (mu_v),
    .p_val     (mu_p),
    .q_val     (mu_q),
    .t_val     (mu_t),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule

`default_nettype wire

// File: design/hsb_front.sv
// Input stage: hue wrap, saturation/brightness clamp, hue*6 sector split.
// Depends on hsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsb_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [FRAC_BITS:0]    hue_frac,
  input  wire  [FRAC_BITS:0]    saturation_frac,
  input  wire  [FRAC_BITS:0]    brightness_frac,
  output logic                  out_valid,
  input  wire                   out_ready,
  output hsb_pkg::sector_t      sector,
  output logic [FRAC_BITS-1:0]  f_frac,
  output logic [FRAC_BITS:0]    s_val,
  output logic [FRAC_BITS:0]    v_val
);
  import hsb_pkg::*;

  localparam int unsigned VAL_W = FRAC_BITS + 1;
  localparam int unsigned H6_W  = FRAC_BITS + 3;
  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [H6_W-1:0]  hue_ext;
  logic [H6_W-1:0]  hue6;
  logic [VAL_W-1:0] s_clamp;
  logic [VAL_W-1:0] v_clamp;

  // hue of 1.0 or more wraps: keep the fraction bits only
  assign hue_ext = H6_W'(hue_frac[FRAC_BITS-1:0]);
  assign hue6    = (hue_ext << 2) + (hue_ext << 1);
  assign s_clamp = (saturation_frac > ONE) ? ONE : saturation_frac;
  assign v_clamp = (brightness_frac > ONE) ? ONE : brightness_frac;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sector <= sector_t'(hue6[H6_W-1:FRAC_BITS]);
      f_frac <= hue6[FRAC_BITS-1:0];
      s_val  <= s_clamp;
      v_val  <= v_clamp;
    end
  end

endmodule

`default_nettype wire

// File: design/hsb_pqt.sv
// Two multiply stages forming p, q and t from v, s and the hue fraction.
// Depends on hsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsb_pqt #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  hsb_pkg::sector_t      sector_in,
  input  wire  [FRAC_BITS-1:0]  f_frac,
  input  wire  [FRAC_BITS:0]    s_val,
  input  wire  [FRAC_BITS:0]    v_in,
  output logic                  out_valid,
  input  wire                   out_ready,
  output hsb_pkg::sector_t      sector_out,
  output logic [FRAC_BITS:0]    v_out,
  output logic [FRAC_BITS:0]    p_out,
  output logic [FRAC_BITS:0]    q_out,
  output logic [FRAC_BITS:0]    t_out
);
  import hsb_pkg::*;

  localparam int unsigned VAL_W  = FRAC_BITS + 1;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage a: s*f, s*(1-f), v*(1-s)
  logic [VAL_W-1:0]  one_minus_f;
  logic [VAL_W-1:0]  one_minus_s;
  logic [PROD_W-1:0] sf_prod;
  logic [PROD_W-1:0] somf_prod;
  logic [PROD_W-1:0] p_prod;
  logic              a_valid;
  logic              a_ready;
  sector_t           a_sector;
  logic [VAL_W-1:0]  a_v;
  logic [VAL_W-1:0]  a_p;
  logic [VAL_W-1:0]  a_sf;
  logic [VAL_W-1:0]  a_somf;

  // stage b: v*(1-sf), v*(1-s(1-f))
  logic [VAL_W-1:0]  one_minus_sf;
  logic [VAL_W-1:0]  one_minus_somf;
  logic [PROD_W-1:0] q_prod;
  logic [PROD_W-1:0] t_prod;

  assign one_minus_f = ONE - VAL_W'(f_frac);
  assign one_minus_s = ONE - s_val;
  assign sf_prod     = PROD_W'(s_val) * PROD_W'(f_frac);
  assign somf_prod   = PROD_W'(s_val) * PROD_W'(one_minus_f);
  assign p_prod      = PROD_W'(v_in)  * PROD_W'(one_minus_s);

  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sector <= sector_in;
      a_v      <= v_in;
      a_p      <= p_prod[FRAC_BITS+VAL_W-1:FRAC_BITS];
      a_sf     <= sf_prod[FRAC_BITS+VAL_W-1:FRAC_BITS];
      a_somf   <= somf_prod[FRAC_BITS+VAL_W-1:FRAC_BITS];
    end
  end

  // products above never exceed 1.0, so these stay non-negative
  assign one_minus_sf   = ONE - a_sf;
  assign one_minus_somf = ONE - a_somf;
  assign q_prod         = PROD_W'(a_v) * PROD_W'(one_minus_sf);
  assign t_prod         = PROD_W'(a_v) * PROD_W'(one_minus_somf);

  assign a_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      sector_out <= a_sector;
      v_out      <= a_v;
      p_out      <= a_p;
      q_out      <= q_prod[FRAC_BITS+VAL_W-1:FRAC_BITS];
      t_out      <= t_prod[FRAC_BITS+VAL_W-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// File: design/hsb_out.sv
// Output stage: channel order by sector, scale to 0..255, output register.
// Depends on hsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsb_out #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  hsb_pkg::sector_t             sector,
  input  wire  [FRAC_BITS:0]           v_val,
  input  wire  [FRAC_BITS:0]           p_val,
  input  wire  [FRAC_BITS:0]           q_val,
  input  wire  [FRAC_BITS:0]           t_val,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hsb_pkg::CHAN_W-1:0]   red,
  output logic [hsb_pkg::CHAN_W-1:0]   green,
  output logic [hsb_pkg::CHAN_W-1:0]   blue
);
  import hsb_pkg::*;

  localparam int unsigned VAL_W = FRAC_BITS + 1;
  localparam int unsigned SC_W  = VAL_W + CHAN_W;

  logic [VAL_W-1:0] r_sel;
  logic [VAL_W-1:0] g_sel;
  logic [VAL_W-1:0] b_sel;
  logic [SC_W-1:0]  r_scaled;
  logic [SC_W-1:0]  g_scaled;
  logic [SC_W-1:0]  b_scaled;

  always_comb begin
    case (sector)
      SEC_RED_YELLOW: begin
        r_sel = v_val; g_sel = t_val; b_sel = p_val;
      end
      SEC_YELLOW_GREEN: begin
        r_sel = q_val; g_sel = v_val; b_sel = p_val;
      end
      SEC_GREEN_CYAN: begin
        r_sel = p_val; g_sel = v_val; b_sel = t_val;
      end
      SEC_CYAN_BLUE: begin
        r_sel = p_val; g_sel = q_val; b_sel = v_val;
      end
      SEC_BLUE_MAGENTA: begin
        r_sel = t_val; g_sel = p_val; b_sel = v_val;
      end
      default: begin
        r_sel = v_val; g_sel = p_val; b_sel = q_val;
      end
    endcase
  end

  // x*255 as (x << 8) - x
  assign r_scaled = (SC_W'(r_sel) << CHAN_W) - SC_W'(r_sel);
  assign g_scaled = (SC_W'(g_sel) << CHAN_W) - SC_W'(g_sel);
  assign b_scaled = (SC_W'(b_sel) << CHAN_W) - SC_W'(b_sel);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red   <= r_scaled[FRAC_BITS+CHAN_W-1:FRAC_BITS];
      green <= g_scaled[FRAC_BITS+CHAN_W-1:FRAC_BITS];
      blue  <= b_scaled[FRAC_BITS+CHAN_W-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// File: tb/hsb_to_rgb_converter_tb.sv
// Stream-level testbench for the HSB to RGB converter: directed and random pixels
// are checked against a bit-exact fixed-point prediction. Depends on hsb_pkg and
// hsb_to_rgb_converter.
`timescale 1ns / 1ps

module hsb_to_rgb_converter_tb;
  import hsb_pkg::*;

  localparam int unsigned FRAC    = 16;
  localparam int unsigned FIELD_W = FRAC + 1;
  localparam int unsigned IN_W    = 8 * ((3 * FIELD_W + 7) / 8);
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam int unsigned N_RANDOM = 1600;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Holds the expected colors in order and checks each output item against them.
  class rgb_checker;
    rgb_t expected_rgb[$];
    int   mismatches;
    int   pixels_in;
    int   pixels_out;
    int   out_of_range_in;
    int   sector_hits[6];

    function automatic logic [7:0] scale_to_byte(longint unsigned x);
      return 8'(((x * CHAN_SCALE) >> FRAC) & 64'hFF);
    endfunction

    function automatic longint unsigned clamp_unit(logic [FIELD_W-1:0] x);
      return (64'(x) > ONE) ? ONE : 64'(x);
    endfunction

    // Fixed-point HSV to RGB; every product truncates.
    function automatic rgb_t hsb_to_rgb(logic [FIELD_W-1:0] hue_in,
                                        logic [FIELD_W-1:0] sat_in,
                                        logic [FIELD_W-1:0] bri_in);
      longint unsigned hue, sat, val, h6, f, p, q, t, r, g, b;
      sector_t sec;
      rgb_t res;
      hue = 64'(hue_in) & (ONE - 1);   // hue wraps modulo one
      sat = clamp_unit(sat_in);
      val = clamp_unit(bri_in);
      h6  = hue * 6;
      sec = sector_t'(3'(h6 >> FRAC));
      f   = h6 & (ONE - 1);
      p   = (val * (ONE - sat)) >> FRAC;
      q   = (val * (ONE - ((sat * f) >> FRAC))) >> FRAC;
      t   = (val * (ONE - ((sat * (ONE - f)) >> FRAC))) >> FRAC;
      case (sec)
        SEC_RED_YELLOW: begin
          r = val; g = t; b = p;
        end
        SEC_YELLOW_GREEN: begin
          r = q; g = val; b = p;
        end
        SEC_GREEN_CYAN: begin
          r = p; g = val; b = t;
        end
        SEC_CYAN_BLUE: begin
          r = p; g = q; b = val;
        end
        SEC_BLUE_MAGENTA: begin
          r = t; g = p; b = val;
        end
        default: begin
          r = val; g = p; b = q;
        end
      endcase
      sector_hits[int'(sec)]++;
      res.red   = scale_to_byte(r);
      res.green = scale_to_byte(g);
      res.blue  = scale_to_byte(b);
      return res;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void note_pixel(logic [IN_W-1:0] data);
      logic [FIELD_W-1:0] h, s, v;
      h = data[FIELD_W-1:0];
      s = data[2*FIELD_W-1:FIELD_W];
      v = data[3*FIELD_W-1:2*FIELD_W];
      if (64'(h) >= ONE || 64'(s) > ONE || 64'(v) > ONE) begin
        out_of_range_in++;
      end
      expected_rgb.push_back(hsb_to_rgb(h, s, v));
      pixels_in++;
    endfunction

    task check_pixel(logic [3*CHAN_W-1:0] data);
      rgb_t got, want;
      got.red   = data[7:0];
      got.green = data[15:8];
      got.blue  = data[23:16];
      pixels_out++;
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("unexpected item r=%0d g=%0d b=%0d",
                                  got.red, got.green, got.blue));
      end else begin
        want = expected_rgb.pop_front();
        if (got.red !== want.red) begin
          report_mismatch($sformatf("item %0d red %0d, expected %0d",
                                    pixels_out - 1, got.red, want.red));
        end
        if (got.green !== want.green) begin
          report_mismatch($sformatf("item %0d green %0d, expected %0d",
                                    pixels_out - 1, got.green, want.green));
        end
        if (got.blue !== want.blue) begin
          report_mismatch($sformatf("item %0d blue %0d, expected %0d",
                                    pixels_out - 1, got.blue, want.blue));
        end
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // hue_frac [16:0], saturation_frac [33:17], brightness_frac [50:34], zeros [55:51]
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // red [7:0], green [15:8], blue [23:16]
  logic [3*CHAN_W-1:0]   m_axis_tdata;

  rgb_checker checker_h = new();
  int  tx_idle_pct = 18;
  int  rx_idle_pct = 45;
  // set at the falling edge when the coming rising edge accepts an input item
  bit  in_fire = 1'b0;

  hsb_to_rgb_converter #(.FRAC_BITS(FRAC)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Everything is sampled mid-cycle, where ports are settled and hold through
  // the next rising edge, so nothing races with the edge itself.
  always @(negedge clk) begin
    in_fire = !rst && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      checker_h.note_pixel(s_axis_tdata);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checker_h.check_pixel(m_axis_tdata);
    end
  end

  // Hold one pixel on the slave side until it is taken; a random idle gap
  // may come first. Valid stays high from one item to the next unless an idle gap is drawn.
  task send_pixel(logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] s,
                  logic [FIELD_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - 3 * FIELD_W){1'b0}}, v, s, h};
    @(posedge clk);
    while (!in_fire) @(posedge clk);
  endtask

  // Mostly legal fractions, with a share of the exact ends and raw 17-bit
  // values that exercise the clamp.
  function automatic logic [FIELD_W-1:0] rand_level();
    case ($urandom_range(9))
      0: return '0;
      1: return FIELD_W'(ONE);
      2: return FIELD_W'(ONE - 1 - $urandom_range(15));
      3: return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(int'(ONE)));
    endcase
  endfunction

  // Hues cluster around sector borders now and then, including the wrap point.
  function automatic logic [FIELD_W-1:0] rand_hue();
    int k;
    case ($urandom_range(7))
      0: begin
        k = $urandom_range(6);
        return FIELD_W'((k * int'(ONE)) / 6 + $urandom_range(8) - 4);
      end
      1: return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(int'(ONE)));
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: black, full red, grey, each sector at full color, sector borders,
    // hue of exactly one and above it, clamped saturation and brightness.
    send_pixel('0, '0, '0);
    send_pixel('0, FIELD_W'(ONE), FIELD_W'(ONE));
    send_pixel(FIELD_W'(ONE), FIELD_W'(ONE), FIELD_W'(ONE));   // hue 1.0 -> red
    send_pixel('1, '1, '1);                                     // all bits set
    send_pixel(FIELD_W'(ONE - 1), FIELD_W'(ONE), FIELD_W'(ONE));
    send_pixel(17'd30000, '0, 17'd40000);                       // grey
    send_pixel(17'd30000, 17'd50000, '0);                       // black
    for (int k = 0; k < 6; k++) begin
      send_pixel(FIELD_W'((2 * k + 1) * int'(ONE) / 12), FIELD_W'(ONE), FIELD_W'(ONE));
    end
    for (int k = 1; k < 6; k++) begin
      send_pixel(FIELD_W'(k * int'(ONE) / 6), 17'd45000, 17'd60000);
    end
    send_pixel(17'd70000, 17'd100000, 17'd65537);               // wrap and clamp
    send_pixel(17'h10000 | 17'd12345, FIELD_W'(ONE + 1), 17'd20000);
    send_pixel(17'h0AAAA, 17'h15555, 17'h1AAAA);

    // Random: receiver idles more than sender, then the reverse, then full rate.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 18;
      end else if (i == 2 * N_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_pixel(rand_hue(), rand_level(), rand_level());
    end
    s_axis_tvalid <= 1'b0;

    while (checker_h.expected_rgb.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Converted %0d pixels, %0d with wrapped hue or clamped levels,",
             checker_h.pixels_in, checker_h.out_of_range_in);
    $display("sector hits %0d/%0d/%0d/%0d/%0d/%0d across three stall patterns",
             checker_h.sector_hits[0], checker_h.sector_hits[1],
             checker_h.sector_hits[2], checker_h.sector_hits[3],
             checker_h.sector_hits[4], checker_h.sector_hits[5]);
    if (checker_h.mismatches == 0 && checker_h.expected_rgb.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: hsb_to_rgb_converter.f
design/hsb_pkg.sv
design/hsb_front.sv
design/hsb_pqt.sv
design/hsb_out.sv
design/hsb_to_rgb_converter.sv
tb/hsb_to_rgb_converter_tb.sv
